// ----- src/pttc_pkg.sv -----
// Package for the pan/tilt tracking controller: fixed-point constants,
// divider request/response types, mapping constants and saturation helpers.
// No dependencies.
package pttc_pkg;

  localparam int OFF_FB   = 8;
  localparam int ANG_FB   = 8;
  localparam int SPD_FB   = 24;
  localparam int SCALE_SH = SPD_FB - OFF_FB;

  localparam int NUM_W = 48;
  localparam int DEN_W = 30;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_STABLE_COUNT = 2'd2;
  localparam logic [1:0] CFG_STUCK_LIMIT  = 2'd3;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W-1:0] quot;
  } div_rsp_t;

  // Per-axis, per-gain-mode mapping constants.
  // c1 = (amid-amin)*k, c2 = 2*(amax-amid), dmul = k-2.
  typedef struct packed {
    logic [2:0] k;
    logic [4:0] c1;
    logic [3:0] c2;
    logic [1:0] dmul;
    logic [3:0] amin;
    logic [3:0] amid;
    logic [3:0] amax;
  } map_cfg_t;

  function automatic map_cfg_t map_cfg(logic axis_y, logic slow);
    map_cfg_t c;
    unique case ({axis_y, slow})
      2'b01:   c = '{k: 3'd3, c1: 5'd12, c2: 4'd8,  dmul: 2'd1,
                     amin: 4'd0, amid: 4'd4, amax: 4'd8};
      2'b00:   c = '{k: 3'd4, c1: 5'd20, c2: 4'd12, dmul: 2'd2,
                     amin: 4'd1, amid: 4'd6, amax: 4'd12};
      2'b11:   c = '{k: 3'd3, c1: 5'd6,  c2: 4'd2,  dmul: 2'd1,
                     amin: 4'd0, amid: 4'd2, amax: 4'd3};
      default: c = '{k: 3'd3, c1: 5'd9,  c2: 4'd4,  dmul: 2'd1,
                     amin: 4'd0, amid: 4'd3, amax: 4'd5};
    endcase
    return c;
  endfunction

  // Saturate a quotient to 32 bits; a zero divisor gives the extreme with
  // the numerator's sign.
  function automatic logic signed [31:0] sat_quot(logic signed [NUM_W-1:0] q,
                                                  logic signed [NUM_W-1:0] n,
                                                  logic dz);
    logic signed [31:0] r;
    if (dz) begin
      if (n > 0)      r = 32'sh7fffffff;
      else if (n < 0) r = 32'sh80000000;
      else            r = '0;
    end else if (q > $signed(NUM_W'(32'sh7fffffff))) begin
      r = 32'sh7fffffff;
    end else if (q < $signed(-NUM_W'(33'sh080000000))) begin
      r = 32'sh80000000;
    end else begin
      r = q[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/pan_tilt_tracking_controller.sv -----
// Pan/tilt tracking controller top level: sequencer, state and output stage.
// Uses pttc_pkg and the shared divider pttc_div.
//
// One frame transaction (time, offsets, match radius) in, one result out
// (matched, pan, tilt, stable). Each division runs on the one shared divider
// at one quotient bit per cycle. With speed history a frame takes four
// speed/acceleration divisions and two mapping divisions; without history
// (first frame, after a drop) only the two mapping divisions; a zero frame
// size skips that axis's division. in_tready is high only in the idle state.
// The finished result sits in an output register, so a new frame is taken
// while it waits to be read.
module pan_tilt_tracking_controller (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // time_ms[26:0], offset_x[50:27], offset_y[74:51], match_radius[97:75]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // matched[0], pan_angle[14:1], tilt_angle[28:15], stable[29]
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [11:0]  cfg_wdata
);

  localparam int NW = pttc_pkg::NUM_W;
  localparam int DW = pttc_pkg::DEN_W;

  typedef enum logic [4:0] {
    S_IDLE, S_VX, S_VXW, S_AX, S_AXW, S_VY, S_VYW, S_AY, S_AYW,
    S_UPD, S_EXT, S_POS, S_MX, S_MXW, S_MY, S_MYW, S_BLEND, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [11:0] fw_r, fh_r, lim_r;
  logic [4:0]  smc_r;

  // captured frame
  logic [26:0]        t_r;
  logic signed [23:0] dx_r, dy_r;
  logic [22:0]        rad_r;

  // tracking history
  logic [27:0]        last_time_r;
  logic signed [23:0] lpx_r, lpy_r;
  logic signed [31:0] speed_x_r, speed_y_r, accel_x_r, accel_y_r;
  logic signed [15:0] last_pan_r, last_tilt_r;
  logic [4:0]         match_run_r;
  logic               stable_r;
  logic signed [3:0]  stuck_r;
  logic               slow_x_r, slow_y_r;

  // working values
  logic signed [31:0] vx_r, vy_r;
  logic signed [44:0] ex_r, ey_r;
  logic signed [41:0] px_r, py_r;
  logic signed [15:0] ax_r, ay_r;
  logic               matched_r;
  logic               mseg1_r, mpos_r;
  pttc_pkg::map_cfg_t mcfg_r;

  pttc_pkg::div_req_t req_r;
  pttc_pkg::div_rsp_t rsp;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  pttc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  // Configuration registers; the user must write them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= 12'd640;
      fh_r  <= 12'd480;
      smc_r <= 5'd16;
      lim_r <= 12'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pttc_pkg::CFG_FRAME_WIDTH:  fw_r  <= cfg_wdata;
        pttc_pkg::CFG_FRAME_HEIGHT: fh_r  <= cfg_wdata;
        pttc_pkg::CFG_STABLE_COUNT: smc_r <= cfg_wdata[4:0];
        pttc_pkg::CFG_STUCK_LIMIT:  lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Elapsed time and history check.
  logic signed [28:0] dt;
  logic               dt_zero;
  logic               have_hist;
  logic signed [24:0] diff_x, diff_y;
  logic signed [31:0] q32;
  logic signed [32:0] cx_sum, cx_adj;

  always_comb begin
    dt        = $signed({2'b00, t_r}) - $signed({last_time_r[27], last_time_r});
    dt_zero   = (dt == '0);
    have_hist = !last_time_r[27] && (last_time_r != '0);
    diff_x    = $signed({dx_r[23], dx_r}) - $signed({lpx_r[23], lpx_r});
    diff_y    = $signed({dy_r[23], dy_r}) - $signed({lpy_r[23], lpy_r});
    q32       = pttc_pkg::sat_quot(rsp.quot, req_r.num, dt_zero);
    // average new and old speed, halved toward zero
    if (state_r == S_VYW) cx_sum = $signed({q32[31], q32}) + $signed({speed_y_r[31], speed_y_r});
    else                  cx_sum = $signed({q32[31], q32}) + $signed({speed_x_r[31], speed_x_r});
    cx_adj = cx_sum + $signed({32'b0, cx_sum[32]});
  end

  // History drop, match and gain-mode update.
  logic       clr;
  logic [23:0] abs_dx;
  logic       matched;
  logic [4:0] mr_base, mr_new;
  logic       stable_new;
  logic       slow_x_new, slow_y_new;
  logic signed [23:0] lpx_base, lpy_base;

  always_comb begin
    clr = (vx_r > 32'sd16777216) || (vx_r < -32'sd16777216) ||
          (vy_r > 32'sd8388608)  || (vy_r < -32'sd8388608);
    abs_dx   = dx_r[23] ? 24'(-dx_r) : 24'(dx_r);
    matched  = abs_dx < {1'b0, rad_r};
    mr_base  = clr ? 5'd0 : match_run_r;
    lpx_base = clr ? 24'sd0 : lpx_r;
    lpy_base = clr ? 24'sd0 : lpy_r;
    if (matched) begin
      mr_new     = (mr_base == 5'd31) ? mr_base : mr_base + 5'd1;
      stable_new = (clr ? 1'b0 : stable_r) || (mr_new >= smc_r);
    end else begin
      mr_new     = 5'd0;
      stable_new = 1'b0;
    end
    slow_x_new = clr ? 1'b1 : slow_x_r;
    slow_y_new = clr ? 1'b1 : slow_y_r;
    if (stable_new) begin
      slow_x_new = 1'b0;
      slow_y_new = 1'b0;
    end else begin
      if ((dx_r > 0 && lpx_base < 0) || (dx_r < 0 && lpx_base > 0)) slow_x_new = 1'b1;
      if ((dy_r > 0 && lpy_base < 0) || (dy_r < 0 && lpy_base > 0)) slow_y_new = 1'b1;
    end
  end

  // Extrapolation: ex = v + 4000*a, then position += ex*gain / 2^16.
  logic signed [44:0] ex_nxt, ey_nxt;
  logic signed [51:0] pxp, pyp, pxa, pya;
  logic signed [51:0] pxs, pys;

  always_comb begin
    ex_nxt = 45'(accel_x_r) * 45'sd4000 + 45'(vx_r);
    ey_nxt = 45'(accel_y_r) * 45'sd4000 + 45'(vy_r);
    pxp    = 52'(ex_r) * 52'sd100;
    pyp    = 52'(ey_r) * 52'sd60;
    pxa    = (pxp + (pxp[51] ? 52'sd65535 : 52'sd0)) >>> pttc_pkg::SCALE_SH;
    pya    = (pyp + (pyp[51] ? 52'sd65535 : 52'sd0)) >>> pttc_pkg::SCALE_SH;
    pxs    = 52'(dx_r) + pxa;
    pys    = 52'(dy_r) + pya;
    if (pxs > 52'sh10000000000)  pxs = 52'sh10000000000;
    if (pxs < -52'sh10000000000) pxs = -52'sh10000000000;
    if (pys > 52'sh10000000000)  pys = 52'sh10000000000;
    if (pys < -52'sh10000000000) pys = -52'sh10000000000;
  end

  // Piecewise map, shared by both axes: setup and finish.
  logic               axis_y;
  logic signed [41:0] mpos;
  logic [11:0]        msize;
  pttc_pkg::map_cfg_t mcfg;
  logic               mpos_gt;
  logic [41:0]        mabs;
  logic [44:0]        mlhs, mrhs;
  logic               mseg1;
  logic signed [45:0] mkpos, msz_s, mt;
  logic signed [NW-1:0] mnum;
  logic [DW-1:0]      mden;
  logic signed [15:0] zang;
  logic [3:0]         foff;
  logic signed [48:0] foff_s, flim, fa;
  logic signed [15:0] fang;

  always_comb begin
    axis_y  = (state_r == S_MY);
    mpos    = axis_y ? py_r : px_r;
    msize   = axis_y ? fh_r : fw_r;
    mcfg    = pttc_pkg::map_cfg(axis_y, axis_y ? slow_y_r : slow_x_r);
    mpos_gt = !mpos[41] && (mpos != '0);
    mabs    = mpos[41] ? 42'(-mpos) : 42'(mpos);
    mlhs    = 45'(mabs) * 45'(mcfg.k);
    mrhs    = 45'(msize) << pttc_pkg::OFF_FB;
    mseg1   = mlhs < mrhs;
    mkpos   = 46'(mpos) * $signed(46'(mcfg.k));
    msz_s   = $signed(46'(msize) << pttc_pkg::OFF_FB);
    mt      = mkpos - (mpos_gt ? msz_s : -msz_s);
    // angle and offset scales share the same fraction width and cancel
    if (mseg1) begin
      mnum = NW'(mpos) * $signed(NW'(mcfg.c1));
      mden = DW'(msize);
    end else begin
      mnum = NW'(mt) * $signed(NW'(mcfg.c2));
      mden = DW'(msize) * DW'(mcfg.dmul);
    end
    zang = mpos_gt ? $signed(16'(mcfg.amax) << pttc_pkg::ANG_FB)
                   : -$signed(16'(mcfg.amax) << pttc_pkg::ANG_FB);

    foff   = mseg1_r ? mcfg_r.amin : mcfg_r.amid;
    foff_s = $signed(49'(foff) << pttc_pkg::ANG_FB);
    flim   = $signed(49'(mcfg_r.amax) << pttc_pkg::ANG_FB);
    fa     = 49'(rsp.quot) + (mpos_r ? foff_s : -foff_s);
    if (fa > flim || fa < -flim) fa = mpos_r ? flim : -flim;
    fang   = fa[15:0];
  end

  // Blend 5:1 with the previous angle, divide by 6 via reciprocal.
  function automatic logic signed [15:0] blend6(logic signed [15:0] a,
                                                logic signed [15:0] prev);
    logic signed [18:0] s;
    logic [17:0]        m;
    logic [34:0]        p;
    logic [15:0]        q;
    s = 19'(a) * 19'sd5 + 19'(prev);
    m = s[18] ? 18'(-s) : 18'(s);
    p = 35'(m) * 35'd43691;
    q = p[33:18];
    return s[18] ? -$signed(q) : $signed(q);
  endfunction

  logic signed [15:0] pan_b, tilt_b, pan_f;
  logic [15:0]        abs_pan;
  logic signed [3:0]  stuck_nxt;

  always_comb begin
    pan_b   = blend6(ax_r, last_pan_r);
    tilt_b  = blend6(ay_r, last_tilt_r);
    abs_pan = pan_b[15] ? 16'(-pan_b) : 16'(pan_b);
    stuck_nxt = (abs_pan > {4'b0, lim_r}) ? stuck_r - 4'sd1 : 4'sd3;
    if (stuck_nxt == 4'sd0) stuck_nxt = -4'sd2;
    pan_f = pan_b;
    if (stuck_nxt < 0) begin
      stuck_nxt = stuck_nxt + 4'sd1;
      pan_f     = (pan_b + $signed({15'b0, pan_b[15]})) >>> 1;
    end
  end

  // Divider start and output valid, each from a single next value.
  logic start_nxt;
  logic out_load;
  logic out_valid_nxt;

  always_comb begin
    unique case (state_r)
      S_VX:             start_nxt = have_hist;
      S_AX, S_VY, S_AY: start_nxt = 1'b1;
      S_MX, S_MY:       start_nxt = (msize != '0);
      default:          start_nxt = 1'b0;
    endcase
    // hold until the output register is free
    out_load      = (state_r == S_OUT) && (!out_valid_r || out_tready);
    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      req_r.start <= 1'b0;
      last_time_r <= '1;
      lpx_r       <= '0;
      lpy_r       <= '0;
      speed_x_r   <= '0;
      speed_y_r   <= '0;
      accel_x_r   <= '0;
      accel_y_r   <= '0;
      last_pan_r  <= '0;
      last_tilt_r <= '0;
      match_run_r <= '0;
      stable_r    <= 1'b0;
      stuck_r     <= 4'sd5;
      slow_x_r    <= 1'b1;
      slow_y_r    <= 1'b1;
    end else begin
      req_r.start <= start_nxt;
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            t_r   <= in_tdata[26:0];
            dx_r  <= in_tdata[50:27];
            dy_r  <= in_tdata[74:51];
            rad_r <= in_tdata[97:75];
            vx_r  <= '0;
            vy_r  <= '0;
            state_r <= S_VX;
          end
        end
        S_VX: begin
          if (have_hist) begin
            req_r.num   <= {{(NW-25){diff_x[24]}}, diff_x} <<< pttc_pkg::SCALE_SH;
            req_r.den   <= DW'(dt);
            state_r     <= S_VXW;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_VXW: begin
          if (rsp.done) begin
            vx_r    <= cx_adj[32:1];
            state_r <= S_AX;
          end
        end
        S_AX: begin
          req_r.num   <= NW'($signed({vx_r[31], vx_r}) - $signed({speed_x_r[31], speed_x_r}));
          state_r     <= S_AXW;
        end
        S_AXW: begin
          if (rsp.done) begin
            accel_x_r <= q32;
            state_r   <= S_VY;
          end
        end
        S_VY: begin
          req_r.num   <= {{(NW-25){diff_y[24]}}, diff_y} <<< pttc_pkg::SCALE_SH;
          state_r     <= S_VYW;
        end
        S_VYW: begin
          if (rsp.done) begin
            vy_r    <= cx_adj[32:1];
            state_r <= S_AY;
          end
        end
        S_AY: begin
          req_r.num   <= NW'($signed({vy_r[31], vy_r}) - $signed({speed_y_r[31], speed_y_r}));
          state_r     <= S_AYW;
        end
        S_AYW: begin
          if (rsp.done) begin
            accel_y_r <= q32;
            state_r   <= S_UPD;
          end
        end
        S_UPD: begin
          // drop all history on a speed beyond the limit
          speed_x_r   <= clr ? 32'sd0 : vx_r;
          speed_y_r   <= clr ? 32'sd0 : vy_r;
          last_time_r <= clr ? '1 : {1'b0, t_r};
          if (clr) begin
            accel_x_r   <= '0;
            accel_y_r   <= '0;
            last_pan_r  <= '0;
            last_tilt_r <= '0;
            stuck_r     <= 4'sd5;
          end
          match_run_r <= mr_new;
          stable_r    <= stable_new;
          slow_x_r    <= slow_x_new;
          slow_y_r    <= slow_y_new;
          matched_r   <= matched;
          lpx_r       <= dx_r;
          lpy_r       <= dy_r;
          state_r     <= S_EXT;
        end
        S_EXT: begin
          ex_r    <= ex_nxt;
          ey_r    <= ey_nxt;
          state_r <= S_POS;
        end
        S_POS: begin
          px_r    <= stable_r ? pxs[41:0] : 42'(dx_r);
          py_r    <= stable_r ? pys[41:0] : 42'(dy_r);
          state_r <= S_MX;
        end
        S_MX: begin
          mseg1_r <= mseg1;
          mpos_r  <= mpos_gt;
          mcfg_r  <= mcfg;
          if (msize == '0) begin
            ax_r    <= zang;
            state_r <= S_MY;
          end else begin
            req_r.num   <= mnum;
            req_r.den   <= mden;
            state_r     <= S_MXW;
          end
        end
        S_MXW: begin
          if (rsp.done) begin
            ax_r    <= fang;
            state_r <= S_MY;
          end
        end
        S_MY: begin
          mseg1_r <= mseg1;
          mpos_r  <= mpos_gt;
          mcfg_r  <= mcfg;
          if (msize == '0) begin
            ay_r    <= zang;
            state_r <= S_BLEND;
          end else begin
            req_r.num   <= mnum;
            req_r.den   <= mden;
            state_r     <= S_MYW;
          end
        end
        S_MYW: begin
          if (rsp.done) begin
            ay_r    <= fang;
            state_r <= S_BLEND;
          end
        end
        S_BLEND: begin
          last_pan_r  <= pan_f;
          last_tilt_r <= tilt_b;
          stuck_r     <= stuck_nxt;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r  <= {2'b00, stable_r, last_tilt_r[13:0], last_pan_r[13:0], matched_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/pttc_div.sv -----
// Shared signed divider for the pan/tilt tracking controller: restoring,
// one quotient bit per cycle, truncates toward zero. Uses pttc_pkg.
module pttc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pttc_pkg::div_req_t req,
  output pttc_pkg::div_rsp_t rsp
);

  localparam int NW = pttc_pkg::NUM_W;
  localparam int DW = pttc_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] nmag_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dmag_r;
  logic          neg_r;
  logic          done_r;
  logic signed [NW-1:0] quot_r;

  logic [DW:0]   trial;
  logic          qbit;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] q_nxt;

  always_comb begin
    trial   = {rem_r, nmag_r[NW-1]};
    qbit    = (trial >= {1'b0, dmag_r});
    rem_nxt = qbit ? DW'(trial - {1'b0, dmag_r}) : trial[DW-1:0];
    q_nxt   = {nmag_r[NW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW - 1);
        nmag_r <= req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
        dmag_r <= req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
        neg_r  <= req.num[NW-1] ^ req.den[DW-1];
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        nmag_r <= q_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= neg_r ? -$signed(q_nxt) : $signed(q_nxt);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
